@@ src/pixel_replication_upscaler_assert.svh @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler assertion macros
// Shared macros for the concurrent checks in the upscaler modules.
// ----------------------------------------------------------------------------
`ifndef PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PRU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define PRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler package
// Shared constants, codes, types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned MAX_SCALE    = 100;
  localparam int unsigned HEIGHT_LIMIT = 4096;

  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned SCALE_W  = 7;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned PAD_W    = 2;
  localparam int unsigned LB_AW    = $clog2(MAX_WIDTH);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               use_mem;
    logic [PIXEL_W-1:0] pixel;
    logic               taken;
    logic               row_end;
    logic               img_end;
  } pru_meta_t;

  // Padding bytes needed to round width * scale * 3 up to a multiple of four.
  function automatic logic [PAD_W-1:0] pad_bytes(input logic [1:0] w_lo,
                                                 input logic [1:0] s_lo);
    logic [3:0] prod;
    logic [5:0] bytes;
    begin
      prod  = 4'(w_lo) * 4'(s_lo);
      bytes = 6'(prod) * 6'd3;
      return PAD_W'(6'd0 - bytes);
    end
  endfunction

endpackage

`default_nettype wire

@@ src/pru_src_if.sv @@
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying the head of the source pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface pru_src_if;
  logic        valid;
  logic        ready;
  logic [23:0] source_pixel;
  logic        source_valid;

  modport source (output valid, output source_pixel, output source_valid, input ready);
  modport sink   (input valid, input source_pixel, input source_valid, output ready);
endinterface

`default_nettype wire

@@ src/pru_elem_if.sv @@
// ----------------------------------------------------------------------------
// Output element channel
// Valid/ready channel carrying one upscaled pixel or padding byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface pru_elem_if;
  logic        valid;
  logic        ready;
  logic        element_kind;
  logic [23:0] out_pixel;
  logic        source_taken;
  logic        row_end;
  logic        image_end;

  modport source (output valid, output element_kind, output out_pixel, output source_taken,
                  output row_end, output image_end, input ready);
  modport sink   (input valid, input element_kind, input out_pixel, input source_taken,
                  input row_end, input image_end, output ready);
endinterface

`default_nettype wire

@@ src/pru_line_buf.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler line buffer
// One row of source pixels, one write and one registered read per cycle on one address.
// ----------------------------------------------------------------------------
`default_nettype none

module pru_line_buf
  import pru_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic               re_i,
  input  wire logic [LB_AW-1:0]   addr_i,
  input  wire logic [PIXEL_W-1:0] wdata_i,
  output logic      [PIXEL_W-1:0] rdata_o
);

  logic [PIXEL_W-1:0] mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/pru_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler control
// Configuration registers, row and column counters and the stage register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_replication_upscaler_assert.svh"

module pru_ctrl
  import pru_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  pru_src_if.sink                    src_i,
  input  wire logic                  adv_i,
  output logic                       s1_valid_o,
  output pru_meta_t                  meta_o,
  output logic                       lb_we_o,
  output logic                       lb_re_o,
  output logic      [LB_AW-1:0]      lb_addr_o
);

  logic [SCALE_W-1:0]  scale_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  logic [WIDTH_W-1:0]  col_q, col_d, col_inc;
  logic [SCALE_W-1:0]  hr_q, hr_d, hr_inc;
  logic [SCALE_W-1:0]  vr_q, vr_d, vr_inc;
  logic [ROW_W-1:0]    rc_q, rc_d;
  logic [HEIGHT_W-1:0] rc_inc;
  logic [PAD_W-1:0]    pad_q, pad_d, pc_inc, pad_len;
  logic                in_pad_q, in_pad_d;
  logic                fin_q, fin_d;

  logic                cfg_hit;
  logic                need_src;
  logic                produce;
  logic                accept;
  logic                step;
  logic                close_row;
  logic                s1_valid_q;
  pru_meta_t           meta_d, meta_q;

  always_comb begin
    case (cfg_idx_i)
      REG_SCALE:  cfg_hit = cfg_we_i;
      REG_WIDTH:  cfg_hit = cfg_we_i;
      REG_HEIGHT: cfg_hit = cfg_we_i;
      default:    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(1);
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE: begin
          if (cfg_data_i[SCALE_W-1:0] == '0) begin
            scale_q <= SCALE_W'(1);
          end else if (cfg_data_i[SCALE_W-1:0] > SCALE_W'(MAX_SCALE)) begin
            scale_q <= SCALE_W'(MAX_SCALE);
          end else begin
            scale_q <= cfg_data_i[SCALE_W-1:0];
          end
        end
        REG_WIDTH: begin
          if (cfg_data_i[WIDTH_W-1:0] == '0) begin
            width_q <= WIDTH_W'(1);
          end else if (cfg_data_i[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) begin
            width_q <= WIDTH_W'(MAX_WIDTH);
          end else begin
            width_q <= cfg_data_i[WIDTH_W-1:0];
          end
        end
        REG_HEIGHT: begin
          if (cfg_data_i[HEIGHT_W-1:0] == '0) begin
            height_q <= HEIGHT_W'(1);
          end else if (cfg_data_i[HEIGHT_W-1:0] > HEIGHT_W'(HEIGHT_LIMIT)) begin
            height_q <= HEIGHT_W'(HEIGHT_LIMIT);
          end else begin
            height_q <= cfg_data_i[HEIGHT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pad_len  = pad_bytes(width_q[1:0], scale_q[1:0]);
  assign need_src = !in_pad_q && (vr_q == '0) && (hr_q == '0);
  assign produce  = !fin_q && !(need_src && !src_i.source_valid);
  assign accept   = src_i.valid && src_i.ready;
  assign step     = accept && produce;

  assign pc_inc  = pad_q + PAD_W'(1);
  assign hr_inc  = hr_q + SCALE_W'(1);
  assign col_inc = col_q + WIDTH_W'(1);
  assign vr_inc  = vr_q + SCALE_W'(1);
  assign rc_inc  = {1'b0, rc_q} + HEIGHT_W'(1);

  always_comb begin
    col_d     = col_q;
    hr_d      = hr_q;
    vr_d      = vr_q;
    rc_d      = rc_q;
    pad_d     = pad_q;
    in_pad_d  = in_pad_q;
    fin_d     = fin_q;
    close_row = 1'b0;
    meta_d    = '0;

    if (in_pad_q) begin
      meta_d.kind = KIND_PAD;
      pad_d       = pc_inc;
      if ((pc_inc >= pad_len) || (pc_inc == '0)) begin
        pad_d     = '0;
        in_pad_d  = 1'b0;
        close_row = 1'b1;
      end
    end else begin
      meta_d.kind    = KIND_PIXEL;
      meta_d.use_mem = !need_src;
      meta_d.taken   = need_src;
      meta_d.pixel   = need_src ? src_i.source_pixel : '0;
      hr_d           = hr_inc;
      if (hr_inc >= scale_q) begin
        hr_d  = '0;
        col_d = col_inc;
        if (col_inc >= width_q) begin
          col_d = '0;
          if (pad_len != '0) begin
            in_pad_d = 1'b1;
            pad_d    = '0;
          end else begin
            close_row = 1'b1;
          end
        end
      end
    end

    if (close_row) begin
      meta_d.row_end = 1'b1;
      vr_d           = vr_inc;
      if (vr_inc >= scale_q) begin
        vr_d = '0;
        rc_d = rc_inc[ROW_W-1:0];
        if (rc_inc >= height_q) begin
          rc_d           = '0;
          fin_d          = 1'b1;
          meta_d.img_end = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      hr_q     <= '0;
      vr_q     <= '0;
      rc_q     <= '0;
      pad_q    <= '0;
      in_pad_q <= 1'b0;
      fin_q    <= 1'b0;
    end else if (cfg_hit) begin
      col_q    <= '0;
      hr_q     <= '0;
      vr_q     <= '0;
      rc_q     <= '0;
      pad_q    <= '0;
      in_pad_q <= 1'b0;
      fin_q    <= 1'b0;
    end else if (step) begin
      col_q    <= col_d;
      hr_q     <= hr_d;
      vr_q     <= vr_d;
      rc_q     <= rc_d;
      pad_q    <= pad_d;
      in_pad_q <= in_pad_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= produce;
    end else if (adv_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= meta_d;
    end
  end

  assign src_i.ready = !s1_valid_q || adv_i;
  assign s1_valid_o  = s1_valid_q;
  assign meta_o      = meta_q;
  assign lb_we_o     = step && meta_d.taken;
  assign lb_re_o     = step && meta_d.use_mem;
  assign lb_addr_o   = col_q[LB_AW-1:0];

  `PRU_ASSERT(a_hrep_below_scale, clk_i, rst_ni, hr_q < scale_q, "horizontal repeat reached scale")
  `PRU_ASSERT_IMPL(a_pad_below_len, clk_i, rst_ni, in_pad_q, pad_q < pad_len,
                   "padding count reached padding length")
  `PRU_ASSERT_IMPL(a_fin_counters_clear, clk_i, rst_ni, fin_q,
                   !in_pad_q && (hr_q == '0) && (col_q == '0) && (vr_q == '0),
                   "counters not cleared at image end")

endmodule

`default_nettype wire

@@ src/pru_out_reg.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler output register
// Holds one finished element until the downstream transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_replication_upscaler_assert.svh"

module pru_out_reg
  import pru_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s1_valid_i,
  input  wire pru_meta_t          meta_i,
  input  wire logic [PIXEL_W-1:0] rdata_i,
  output logic                    adv_o,
  pru_elem_if.source              elem_o
);

  logic               out_valid_q;
  logic               kind_q;
  logic [PIXEL_W-1:0] pixel_q;
  logic               taken_q;
  logic               row_end_q;
  logic               img_end_q;

  assign adv_o = !out_valid_q || elem_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      kind_q    <= meta_i.kind;
      pixel_q   <= meta_i.use_mem ? rdata_i : meta_i.pixel;
      taken_q   <= meta_i.taken;
      row_end_q <= meta_i.row_end;
      img_end_q <= meta_i.img_end;
    end
  end

  assign elem_o.valid        = out_valid_q;
  assign elem_o.element_kind = kind_q;
  assign elem_o.out_pixel    = pixel_q;
  assign elem_o.source_taken = taken_q;
  assign elem_o.row_end      = row_end_q;
  assign elem_o.image_end    = img_end_q;

  `PRU_ASSERT_IMPL(a_pad_is_blank, clk_i, rst_ni, out_valid_q && (kind_q == KIND_PAD),
                   (pixel_q == '0) && !taken_q, "padding element carries pixel data")
  `PRU_ASSERT_IMPL(a_img_end_on_row_end, clk_i, rst_ni, out_valid_q && img_end_q, row_end_q,
                   "image end without row end")
  `PRU_ASSERT_IMPL(a_taken_is_pixel, clk_i, rst_ni, out_valid_q && taken_q,
                   kind_q == KIND_PIXEL, "source taken on a padding element")

endmodule

`default_nettype wire

@@ src/pixel_replication_upscaler.sv @@
// ----------------------------------------------------------------------------
// Pixel replication upscaler
// Integer nearest-neighbor upscaler for 24-bit pixel rows with row padding.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// src_i     in         source_pixel[23:0], source_valid
// elem_o    out        element_kind, out_pixel[23:0], source_taken, row_end, image_end
// cfg       in         cfg_we_i, cfg_idx_i[1:0], cfg_data_i[12:0]
//
// Each accepted input transfer yields at most one element, which leaves through
// the stage register and then the output register.
// One input transfer can be accepted every cycle while the output is drained.
// The line buffer takes one write or one read per cycle, which keeps up with that rate.
// Reset clears all counters; the line buffer is not cleared and needs no sweep.
// A stalled output holds its element while one more transfer waits in the stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_replication_upscaler
  import pru_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  pru_src_if.sink                    src_i,
  pru_elem_if.source                 elem_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic               adv;
  logic               s1_valid;
  pru_meta_t          meta;
  logic               lb_we;
  logic               lb_re;
  logic [LB_AW-1:0]   lb_addr;
  logic [PIXEL_W-1:0] lb_rdata;

  pru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .src_i      (src_i),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .meta_o     (meta),
    .lb_we_o    (lb_we),
    .lb_re_o    (lb_re),
    .lb_addr_o  (lb_addr)
  );

  pru_line_buf u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .re_i    (lb_re),
    .addr_i  (lb_addr),
    .wdata_i (src_i.source_pixel),
    .rdata_o (lb_rdata)
  );

  pru_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .meta_i     (meta),
    .rdata_i    (lb_rdata),
    .adv_o      (adv),
    .elem_o     (elem_o)
  );

endmodule

`default_nettype wire

@@ dv/tb_pixel_replication_upscaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replication upscaler testbench
// Streams source items through the upscaler and checks every output element
// against a cycle-free predictor of the scaled image, padding included. A few
// short images first cover the default image, the register limits, row replay and
// a mid-image drain, then random images run under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_pixel_replication_upscaler;
  import pru_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 1780;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel;
    logic               taken;
    logic               row_end;
    logic               img_end;
  } element_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pru_src_if src_if ();
  pru_elem_if elem_if ();

  pixel_replication_upscaler u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .src_i     (src_if),
    .elem_o    (elem_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Scaled image state as seen by the predictor.
  logic [SCALE_W-1:0]  scale_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [PIXEL_W-1:0]  row_copy [MAX_WIDTH];
  int unsigned col_cnt;
  int unsigned h_rep;
  int unsigned v_rep;
  int unsigned src_row;
  int unsigned pad_cnt;
  bit          padding_active;
  bit          image_finished;

  element_t pending_elems[$];
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  function automatic int unsigned clamp_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > MAX_SCALE) return MAX_SCALE;
    return scale_reg;
  endfunction

  function automatic int unsigned clamp_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned clamp_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic int unsigned row_pad_bytes();
    int unsigned bytes;
    bytes = clamp_width() * clamp_scale() * 3;
    return (4 - (bytes & 3)) & 3;
  endfunction

  function automatic void restart_image();
    col_cnt        = 0;
    h_rep          = 0;
    v_rep          = 0;
    src_row        = 0;
    pad_cnt        = 0;
    padding_active = 1'b0;
    image_finished = 1'b0;
  endfunction

  function automatic logic close_output_row();
    v_rep++;
    if (v_rep >= clamp_scale()) begin
      v_rep = 0;
      src_row++;
      if (src_row >= clamp_height()) begin
        src_row        = 0;
        image_finished = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic upscale_step(input logic [PIXEL_W-1:0] px, input logic vld);
    element_t    e;
    int unsigned col;
    if (image_finished) return;
    e = '0;
    e.kind = KIND_PIXEL;
    if (padding_active) begin
      e.kind  = KIND_PAD;
      pad_cnt = (pad_cnt + 1) & 3;
      if (pad_cnt >= row_pad_bytes() || pad_cnt == 0) begin
        pad_cnt        = 0;
        padding_active = 1'b0;
        e.row_end      = 1'b1;
        e.img_end      = close_output_row();
      end
    end else begin
      col = col_cnt % MAX_WIDTH;
      if (v_rep == 0 && h_rep == 0) begin
        if (!vld) return;
        e.pixel                   = px;
        row_copy[col[LB_AW-1:0]]  = px;
        e.taken                   = 1'b1;
      end else begin
        e.pixel = row_copy[col[LB_AW-1:0]];
      end
      h_rep++;
      if (h_rep >= clamp_scale()) begin
        h_rep = 0;
        col_cnt++;
        if (col_cnt >= clamp_width()) begin
          col_cnt = 0;
          if (row_pad_bytes() > 0) begin
            padding_active = 1'b1;
            pad_cnt        = 0;
          end else begin
            e.row_end = 1'b1;
            e.img_end = close_output_row();
          end
        end
      end
    end
    pending_elems.push_back(e);
  endtask

  function automatic void check_field(input string name, input logic [PIXEL_W-1:0] want,
                                      input logic [PIXEL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : elem_checker
    element_t want;
    if (rst_ni && elem_if.valid && elem_if.ready) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected element, expected none, actual kind %0b pixel %0h",
                 $time, elem_if.element_kind, elem_if.out_pixel);
        mismatch_count++;
      end else begin
        want = pending_elems.pop_front();
        check_field("element_kind", PIXEL_W'(want.kind), PIXEL_W'(elem_if.element_kind));
        check_field("out_pixel", want.pixel, elem_if.out_pixel);
        check_field("source_taken", PIXEL_W'(want.taken), PIXEL_W'(elem_if.source_taken));
        check_field("row_end", PIXEL_W'(want.row_end), PIXEL_W'(elem_if.row_end));
        check_field("image_end", PIXEL_W'(want.img_end), PIXEL_W'(elem_if.image_end));
      end
    end
  end

  always @(negedge clk_i) begin
    elem_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic [PIXEL_W-1:0] px, input logic vld);
    while ($urandom_range(99) < src_idle_pct) begin
      src_if.valid = 1'b0;
      @(negedge clk_i);
    end
    src_if.valid        = 1'b1;
    src_if.source_pixel = px;
    src_if.source_valid = vld;
    forever begin
      @(posedge clk_i);
      if (src_if.ready) break;
    end
    upscale_step(px, vld);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    src_if.valid = 1'b0;
    while (pending_elems.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_SCALE: scale_reg = data[SCALE_W-1:0];
      REG_WIDTH: width_reg = data[WIDTH_W-1:0];
      REG_HEIGHT: height_reg = data[HEIGHT_W-1:0];
      default: return;
    endcase
    restart_image();
  endtask

  task automatic set_idling(input int unsigned pattern);
    case (pattern % 4)
      0: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_idle_pct   = 56;
        sink_stall_pct = 0;
      end
      2: begin
        src_idle_pct   = 0;
        sink_stall_pct = 56;
      end
      default: begin
        src_idle_pct   = 29;
        sink_stall_pct = 29;
      end
    endcase
  endtask

  task automatic configure(input int unsigned s, input int unsigned w, input int unsigned h);
    settle();
    cfg_write(REG_SCALE, CFG_DATA_W'(s));
    cfg_write(REG_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  // A starved transfer and a transfer after the end of the image both give nothing.
  task automatic test_default_image();
    send_item(24'h123456, 1'b0);
    send_item(24'hFFFFFF, 1'b1);
    send_item(24'h000000, 1'b0);
    send_item(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_register_limits();
    configure(0, 0, 0);
    cfg_write(REG_UNUSED, 13'h1FFF);
    send_item(24'h000000, 1'b1);
    send_item(24'hFFFFFF, 1'b1);
    configure(13'h1FFF, 13'h1FFF, 13'h1FFF);
    send_item(24'hFFFFFF, 1'b1);
    send_item(24'h000000, 1'b0);
    send_item(24'hA5A5A5, 1'b1);
    send_item(24'h5A5A5A, 1'b0);
    send_item(24'h800001, 1'b1);
    send_item(24'h000000, 1'b1);
  endtask

  task automatic test_row_replay();
    configure(2, 2, 1);
    send_item(24'h0F0F0F, 1'b1);
    send_item(24'hF0F0F0, 1'b0);
    send_item(24'h000000, 1'b0);
    send_item(24'hC3C3C3, 1'b1);
    for (int i = 0; i < 5; i++) send_item(24'(~i), 1'b0);
  endtask

  task automatic test_mid_image_drain();
    set_idling(3);
    configure(3, 5, 2);
    for (int i = 0; i < 40; i++) send_item(24'($urandom), 1'b1);
    wait_drained();
    while (!image_finished) send_item(24'($urandom), $urandom_range(99) >= 10);
  endtask

  task automatic test_random_images();
    int unsigned total_sent;
    int unsigned image_idx;
    int unsigned budget;
    int unsigned sent;
    total_sent = 0;
    image_idx  = 0;
    while (total_sent < RANDOM_ITEMS) begin
      image_idx++;
      settle();
      set_idling(image_idx);
      if ($urandom_range(99) < 20) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
      if ($urandom_range(99) < 85) begin
        configure($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 4));
        budget = ($urandom_range(99) < 10) ? $urandom_range(1, 20) : 32'hFFFF_FFFF;
      end else begin
        configure($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191));
        budget = $urandom_range(50, 300);
      end
      sent = 0;
      while (!image_finished && sent < budget && total_sent < RANDOM_ITEMS) begin
        send_item(24'($urandom), $urandom_range(99) >= 12);
        sent++;
        total_sent++;
      end
      if (image_finished && $urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 2)) begin
          send_item(24'($urandom), 1'($urandom_range(1)));
          total_sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_SCALE;
    cfg_data_i          = '0;
    src_if.valid        = 1'b0;
    src_if.source_pixel = '0;
    src_if.source_valid = 1'b0;
    elem_if.ready       = 1'b0;
    scale_reg           = SCALE_W'(1);
    width_reg           = WIDTH_W'(1);
    height_reg          = HEIGHT_W'(1);
    mismatch_count      = 0;
    restart_image();
    set_idling(0);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_image();
    test_register_limits();
    test_row_replay();
    test_mid_image_drain();
    test_random_images();

    settle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
